### rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the top-k sorted list block.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int SCORE_W         = 16;
    localparam int ID_W            = 16;
    localparam int KEEP_LIMIT_W    = 5;

    localparam logic [KEEP_LIMIT_W-1:0] KEEP_LIMIT_RESET = 5'd10;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // one input request
    typedef struct packed {
        cmd_t              command;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    item_id;
    } req_t;

    // one result
    typedef struct packed {
        logic               accepted;
        logic               entry_valid;
        logic [SCORE_W-1:0] out_score;
        logic [ID_W-1:0]    out_id;
        logic               last;
    } rsp_t;

    typedef logic [KEEP_LIMIT_W-1:0] keep_limit_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_WR_NEW,
        S_RESULT,
        S_RD_ISSUE,
        S_RD_EMIT
    } state_t;

endpackage

### rtl/tks_stream_if.sv
// ----------------------------------------------------------------------------
// tks_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface tks_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/top_k_sorted_insert_top.sv
// Sequence: an insert reads and compares the entries below the new score one by one, then
//   decides; if accepted, it moves entries one by one, writes the new one, then gives its result.
// Read-out emits kept entries one by one; clear, unused codes, empty read-out: one result.
// Flow: one request at a time, set by the entry memory walked address by address
//   with one shared compare; the output register lets the next request enter early.
// Reset: the entry count clears and keep_limit returns to 10; entry memory is not cleared.
// ----------------------------------------------------------------------------
// top_k_sorted_insert_top
// Keeps the best scored items in ascending order in a small memory, walked
// one entry at a time by a sequencer with one compare unit.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_top #(
    parameter int MAX_ENTRIES = tks_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tks_stream_if.sink   cfg,
    tks_stream_if.sink   req,
    tks_stream_if.source rsp
);
    import tks_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > KEEP_LIMIT_W) ? CW : KEEP_LIMIT_W;

    localparam logic [LW-1:0] MAX_LW = LW'(MAX_ENTRIES);

    // entry memory
    logic [SCORE_W-1:0] scores_mem [MAX_ENTRIES];
    logic [ID_W-1:0]    ids_mem    [MAX_ENTRIES];
    logic [SCORE_W-1:0] rd_score_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic [IW-1:0]      raddr;
    logic [IW-1:0]      waddr;
    logic               mem_we;
    logic [SCORE_W-1:0] wscore;
    logic [ID_W-1:0]    wid;

    // control and item registers
    state_t             state_reg, state_next;
    logic [CW-1:0]      kept_count_reg, kept_count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               up_reg, up_next;
    logic               above_reg, above_next;
    logic               acc_reg, acc_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [ID_W-1:0]    id_reg, id_next;
    keep_limit_t        keep_limit_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic               out_free;
    logic [LW-1:0]      lim_ext;
    logic [CW-1:0]      eff_lim;
    logic               rd_below;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= KEEP_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            keep_limit_reg <= cfg.payload;
        end
    end

    // clamp the limit to 1..MAX_ENTRIES
    assign lim_ext = LW'(keep_limit_reg);

    always_comb
    begin
        if (lim_ext == '0)
        begin
            eff_lim = CW'(1);
        end
        else if (lim_ext > MAX_LW)
        begin
            eff_lim = CW'(MAX_ENTRIES);
        end
        else
        begin
            eff_lim = CW'(lim_ext);
        end
    end

    // shared compare unit
    assign rd_below = (rd_score_reg < score_reg);

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            scores_mem[waddr] <= wscore;
            ids_mem[waddr]    <= wid;
        end
        rd_score_reg <= scores_mem[raddr];
        rd_id_reg    <= ids_mem[raddr];
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kept_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        up_reg    <= up_next;
        above_reg <= above_next;
        acc_reg   <= acc_next;
        score_reg <= score_next;
        id_reg    <= id_next;
        out_reg   <= out_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        kept_count_next = kept_count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        up_next         = up_reg;
        above_next      = above_reg;
        acc_next        = acc_reg;
        score_next      = score_reg;
        id_next         = id_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        raddr           = idx_reg[IW-1:0];
        waddr           = idx_reg[IW-1:0];
        mem_we          = 1'b0;
        wscore          = rd_score_reg;
        wid             = rd_id_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    score_next = req.payload.score;
                    id_next    = req.payload.item_id;
                    acc_next   = 1'b0;
                    above_next = 1'b0;
                    idx_next   = '0;
                    case (req.payload.command)
                        CMD_INSERT:
                        begin
                            state_next = S_SRCH_RD;
                        end
                        CMD_READ:
                        begin
                            state_next = (kept_count_reg == '0) ? S_RESULT : S_RD_ISSUE;
                        end
                        CMD_CLEAR:
                        begin
                            kept_count_next = '0;
                            state_next      = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            // find the first entry not below the new score
            S_SRCH_RD:
            begin
                if (idx_reg == kept_count_reg)
                begin
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (idx_reg == '0)
                begin
                    above_next = rd_below;
                end
                if (rd_below)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
            end

            // room left: open a slot upward; full: evict the minimum downward, or reject a score not above it
            S_DECIDE:
            begin
                if (kept_count_reg < eff_lim)
                begin
                    up_next    = 1'b1;
                    idx_next   = kept_count_reg;
                    state_next = S_SH_RD;
                end
                else if (above_reg)
                begin
                    up_next    = 1'b0;
                    idx_next   = '0;
                    state_next = S_SH_RD;
                end
                else
                begin
                    acc_next   = 1'b0;
                    state_next = S_RESULT;
                end
            end

            S_SH_RD:
            begin
                if (up_reg && (idx_reg > pos_reg))
                begin
                    raddr      = IW'(idx_reg - 1'b1);
                    state_next = S_SH_WR;
                end
                else if (!up_reg && ((idx_reg + 1'b1) < pos_reg))
                begin
                    raddr      = IW'(idx_reg + 1'b1);
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_WR_NEW;
                end
            end

            S_SH_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = up_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
                state_next = S_SH_RD;
            end

            S_WR_NEW:
            begin
                mem_we   = 1'b1;
                wscore   = score_reg;
                wid      = id_reg;
                acc_next = 1'b1;
                if (up_reg)
                begin
                    waddr           = pos_reg[IW-1:0];
                    kept_count_next = kept_count_reg + 1'b1;
                end
                else
                begin
                    waddr = IW'(pos_reg - 1'b1);
                end
                state_next = S_RESULT;
            end

            // single result for insert, clear, empty read-out and unused codes
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.accepted    = acc_reg;
                    out_next.entry_valid = 1'b0;
                    out_next.out_score   = '0;
                    out_next.out_id      = '0;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_RD_ISSUE:
            begin
                state_next = S_RD_EMIT;
            end

            S_RD_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.accepted    = 1'b0;
                    out_next.entry_valid = 1'b1;
                    out_next.out_score   = rd_score_reg;
                    out_next.out_id      = rd_id_reg;
                    out_next.last        = ((idx_reg + 1'b1) == kept_count_reg);
                    if ((idx_reg + 1'b1) == kept_count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // list never grows past its storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above storage depth");

    // count only steps up by one or clears
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(kept_count_reg) |->
            (kept_count_reg == $past(kept_count_reg) + 1'b1) || (kept_count_reg == '0))
        else $error("entry count changed by an illegal step");

    // read-out only addresses kept entries
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_ISSUE || state_reg == S_RD_EMIT) |-> (idx_reg < kept_count_reg))
        else $error("read-out index beyond kept entries");

    // a result is either an insert outcome or an entry, never both
    a_rsp_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.accepted && out_reg.entry_valid))
        else $error("result marks both accepted and entry_valid");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the top-k sorted list. A shadow copy of the list is updated on
// every accepted request and gives the results due from the block. These are
// checked field by field, in order, against what the block returns. Directed
// cases come first: empty list, extreme values, ties, a full list and a
// lowered limit. Random traffic follows under a series of keep_limit
// settings, with bursty requests and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

    import tks_pkg::*;

    localparam int          ITEMS_PER_PHASE = 64;
    localparam int          QUIET_CYCLES    = 4 * MAX_ENTRIES_DEF + 8;
    localparam int          WATCHDOG_CYCLES = 3000;
    localparam int          MAX_REPORTS     = 40;
    localparam logic [1:0]  CMD_UNUSED_CODE = 2'd3;

    logic clk;
    logic rst_n;

    tks_stream_if #(.payload_t(keep_limit_t)) cfg_if ();
    tks_stream_if #(.payload_t(req_t))        req_if ();
    tks_stream_if #(.payload_t(rsp_t))        rsp_if ();

    top_k_sorted_insert_top #(
        .MAX_ENTRIES (MAX_ENTRIES_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow of the kept list and its limit
    logic [SCORE_W-1:0] list_score [MAX_ENTRIES_DEF];
    logic [ID_W-1:0]    list_id    [MAX_ENTRIES_DEF];
    int unsigned        list_len;
    keep_limit_t        limit_reg;

    rsp_t pending_results [$];

    // bookkeeping for the summary
    int mismatches;
    int n_requests;
    int n_inserts;
    int n_kept;
    int n_reads;
    int n_entries;
    int n_clears;
    int n_unused;
    int n_limit_writes;
    int n_checked;
    int idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one line per mismatch, with a cap on printing
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // append one due result at the tail of the queue
    task automatic queue_result(input rsp_t res);
        pending_results.insert(pending_results.size(), res);
    endtask

    // limit in force: 0 acts as 1, above the depth acts as the depth
    function automatic int unsigned limit_in_force();
        if (limit_reg == '0)
            return 1;
        if (limit_reg > MAX_ENTRIES_DEF)
            return MAX_ENTRIES_DEF;
        return limit_reg;
    endfunction

    // insert into the shadow list, returns whether the item was kept
    function automatic logic list_insert(input logic [SCORE_W-1:0] s,
                                         input logic [ID_W-1:0] id);
        int unsigned pos;
        int unsigned lim;
        int unsigned i;
        lim = limit_in_force();
        pos = 0;
        while (pos < list_len && list_score[pos] < s)
            pos++;
        // room left: open a slot at pos
        if (list_len < lim)
        begin
            for (i = list_len; i > pos; i--)
            begin
                list_score[i] = list_score[i-1];
                list_id[i]    = list_id[i-1];
            end
            list_score[pos] = s;
            list_id[pos]    = id;
            list_len++;
            return 1'b1;
        end
        // full: only a score above the minimum gets in, the minimum drops out
        if (list_len == 0 || s <= list_score[0])
            return 1'b0;
        for (i = 0; i + 1 < pos; i++)
        begin
            list_score[i] = list_score[i+1];
            list_id[i]    = list_id[i+1];
        end
        list_score[pos-1] = s;
        list_id[pos-1]    = id;
        return 1'b1;
    endfunction

    // results due from one accepted request
    task automatic apply_to_list(input req_t r);
        rsp_t res;
        int unsigned k;
        res      = '0;
        res.last = 1'b1;
        n_requests++;
        case (r.command)
            CMD_INSERT:
            begin
                res.accepted = list_insert(r.score, r.item_id);
                n_inserts++;
                if (res.accepted)
                    n_kept++;
                queue_result(res);
            end
            CMD_READ:
            begin
                n_reads++;
                if (list_len == 0)
                    queue_result(res);
                for (k = 0; k < list_len; k++)
                begin
                    res.entry_valid = 1'b1;
                    res.out_score   = list_score[k];
                    res.out_id      = list_id[k];
                    res.last        = (k + 1 == list_len);
                    queue_result(res);
                    n_entries++;
                end
            end
            CMD_CLEAR:
            begin
                n_clears++;
                list_len = 0;
                queue_result(res);
            end
            default:
            begin
                n_unused++;
                queue_result(res);
            end
        endcase
    endtask

    // send one request, valid stays high for a possible next one
    task automatic send_request(input cmd_t c, input logic [SCORE_W-1:0] s,
                                input logic [ID_W-1:0] id);
        req_t r;
        r.command = c;
        r.score   = s;
        r.item_id = id;
        @(negedge clk);
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        apply_to_list(r);
    endtask

    // drop valid for a number of cycles
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // hold off until every due result is back
    task automatic wait_for_drain();
        idle_sender(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_keep_limit(input keep_limit_t v);
        wait_for_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        limit_reg = v;
        n_limit_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // empty list, extreme fields, ties, unused command, clear
    task automatic test_empty_and_extremes();
        send_request(CMD_READ, 16'hFFFF, 16'hFFFF);
        send_request(cmd_t'(CMD_UNUSED_CODE), 16'hFFFF, 16'hFFFF);
        send_request(CMD_INSERT, 16'h0000, 16'h0000);
        send_request(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        send_request(CMD_INSERT, 16'h8000, 16'h1234);
        // equal score goes ahead of the one already kept
        send_request(CMD_INSERT, 16'h8000, 16'h5678);
        send_request(CMD_READ, 16'h0000, 16'h0000);
        send_request(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_request(CMD_READ, 16'h0000, 16'h0000);
    endtask

    // full list: equal score rejected, higher score evicts the minimum
    task automatic test_full_list();
        write_keep_limit(5'd1);
        send_request(CMD_INSERT, 16'h0100, 16'h0001);
        send_request(CMD_INSERT, 16'h0100, 16'h0002);
        send_request(CMD_INSERT, 16'h0101, 16'h0003);
        send_request(CMD_READ, 16'h0000, 16'h0000);
        // limit 0 acts as 1
        write_keep_limit(5'd0);
        send_request(CMD_INSERT, 16'h0102, 16'h0004);
        send_request(CMD_READ, 16'h0000, 16'h0000);
    endtask

    // limit lowered below the count: count holds, only the minimum moves
    task automatic test_limit_lowered();
        write_keep_limit(5'd16);
        send_request(CMD_INSERT, 16'h0300, 16'hA001);
        send_request(CMD_INSERT, 16'h0050, 16'hA002);
        send_request(CMD_INSERT, 16'h0700, 16'hA003);
        send_request(CMD_INSERT, 16'h0200, 16'hA004);
        send_request(CMD_INSERT, 16'h0050, 16'hA005);
        write_keep_limit(5'd2);
        send_request(CMD_INSERT, 16'h0400, 16'hA006);
        send_request(CMD_INSERT, 16'h0010, 16'hA007);
        send_request(CMD_READ, 16'h0000, 16'h0000);
        send_request(CMD_CLEAR, 16'h0000, 16'h0000);
    endtask

    // random traffic under a series of limits
    task automatic test_random_traffic();
        keep_limit_t phase_limit [7];
        int phase;
        int counted;
        int burst_left;
        int pick;
        logic no_gaps;
        logic [SCORE_W-1:0] base;
        logic [SCORE_W-1:0] s;
        phase_limit[0] = 5'd16;
        phase_limit[1] = 5'd31;
        phase_limit[2] = 5'd3;
        phase_limit[3] = 5'd0;
        phase_limit[4] = 5'd1;
        phase_limit[5] = keep_limit_t'($urandom_range(2, 15));
        phase_limit[6] = keep_limit_t'($urandom_range(17, 30));
        for (phase = 0; phase < 7; phase++)
        begin
            write_keep_limit(phase_limit[phase]);
            no_gaps    = ($urandom_range(0, 3) == 0);
            base       = SCORE_W'($urandom_range(0, 16'hFFF0));
            counted    = 0;
            burst_left = $urandom_range(1, 12);
            while (counted < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                // narrow scores give ties, wide ones reach every bit
                if ($urandom_range(0, 9) < 4)
                    s = base + SCORE_W'($urandom_range(0, 7));
                else
                    s = SCORE_W'($urandom);
                if (pick < 74)
                    send_request(CMD_INSERT, s, ID_W'($urandom));
                else if (pick < 88)
                    send_request(CMD_READ, s, ID_W'($urandom));
                else if (pick < 92)
                    send_request(CMD_CLEAR, s, ID_W'($urandom));
                else if (pick < 96)
                    send_request(cmd_t'(CMD_UNUSED_CODE), s, ID_W'($urandom));
                else
                    send_request(CMD_INSERT, base, ID_W'($urandom));
                if (pick < 92 || pick >= 96)
                    counted++;
                // every so often let the block run dry
                if ($urandom_range(0, 59) == 0)
                    wait_for_drain();
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if (!no_gaps && $urandom_range(0, 3) != 0)
                        idle_sender($urandom_range(1, 6));
                end
            end
        end
        // back to the reset value
        write_keep_limit(KEEP_LIMIT_RESET);
        send_request(CMD_READ, 16'h0000, 16'h0000);
    endtask

    // result side stalls, pattern changes every stretch
    initial
    begin : rsp_stall
        int mode;
        int span;
        int phase_cnt;
        rsp_if.ready = 1'b0;
        phase_cnt    = 0;
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(negedge clk);
                phase_cnt++;
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    3: rsp_if.ready <= (phase_cnt % 4 == 0);
                    default: rsp_if.ready <= (phase_cnt % 32 >= 24);
                endcase
            end
        end
    end

    // compare each returned result with the oldest one due
    always @(posedge clk)
    begin : check_results
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none due: %p", got));
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.accepted !== want.accepted)
                    report_mismatch($sformatf("result %0d accepted %b, due %b",
                                              n_checked, got.accepted, want.accepted));
                if (got.entry_valid !== want.entry_valid)
                    report_mismatch($sformatf("result %0d entry_valid %b, due %b",
                                              n_checked, got.entry_valid, want.entry_valid));
                if (got.out_score !== want.out_score)
                    report_mismatch($sformatf("result %0d out_score %h, due %h",
                                              n_checked, got.out_score, want.out_score));
                if (got.out_id !== want.out_id)
                    report_mismatch($sformatf("result %0d out_id %h, due %h",
                                              n_checked, got.out_id, want.out_id));
                if (got.last !== want.last)
                    report_mismatch($sformatf("result %0d last %b, due %b",
                                              n_checked, got.last, want.last));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_CYCLES, pending_results.size());
            $display("** top_k_sorted_insert_top: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        limit_reg      = KEEP_LIMIT_RESET;
        list_len       = 0;
        idle_cycles    = 0;
        mismatches     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_extremes();
        test_full_list();
        test_limit_lowered();
        test_random_traffic();

        // drain, then give stray results time to show up
        wait_for_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never returned", pending_results.size()));

        $display("covered %0d requests: %0d inserts (%0d kept), %0d read-outs (%0d entries),",
                 n_requests, n_inserts, n_kept, n_reads, n_entries);
        $display("%0d clears, %0d unused commands, %0d limit writes; %0d results checked",
                 n_clears, n_unused, n_limit_writes, n_checked);
        if (mismatches == 0)
            $display("** top_k_sorted_insert_top: PASSED **");
        else
            $display("** top_k_sorted_insert_top: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/tks_pkg.sv
rtl/tks_stream_if.sv
rtl/top_k_sorted_insert_top.sv
bench/tb_top.sv
